// ===== sv/gls_pkg.sv =====
// Shared types, constants and helpers for the grid line-of-sight block.
package gls_pkg;

    // Geometry and storage sizes
    localparam int MAX_SIDE    = 64;
    localparam int COORD_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W      = 7;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int KIND_W      = 2;
    localparam int ORDER_W     = 2 * COORD_W + 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);

    // Terrain codes
    localparam logic [KIND_W-1:0] KIND_OPEN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Controller to walker
    typedef struct packed {
        logic load;
        logic step;
    } walk_ctl_t;

    typedef struct packed {
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
    } walk_load_t;

    // Walker to controller
    typedef struct packed {
        logic               emit_valid;
        logic [COORD_W-1:0] emit_x;
        logic [COORD_W-1:0] emit_y;
        logic               done;
    } walk_stat_t;

    // Clamp a side register into the usable range
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        begin
            r = v;
            if (v < SIDE_MIN)
            begin
                r = SIDE_MIN;
            end
            else if (v > SIDE_MAX)
            begin
                r = SIDE_MAX;
            end
            return r;
        end
    endfunction

    // Row-major store address; callers keep x < w and y < height
    function automatic logic [ADDR_W-1:0] cell_index(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y,
                                                     input logic [SIDE_W-1:0]  w);
        logic [COORD_W+SIDE_W-1:0] prod;
        logic [COORD_W+SIDE_W-1:0] sum;
        begin
            prod = (COORD_W+SIDE_W)'(y) * (COORD_W+SIDE_W)'(w);
            sum  = prod + (COORD_W+SIDE_W)'(x);
            return sum[ADDR_W-1:0];
        end
    endfunction

endpackage

// ===== sv/gls_terrain_ram.sv =====
// Single-port terrain store with registered read data.
module gls_terrain_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [gls_pkg::ADDR_W-1:0]  addr,
    input  logic [gls_pkg::KIND_W-1:0]  wdata,
    output logic [gls_pkg::KIND_W-1:0]  rdata
);

    logic [gls_pkg::KIND_W-1:0] mem [gls_pkg::STORE_DEPTH];
    logic [gls_pkg::KIND_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gls_walk.sv =====
// Supercover walk sequencer: emits one cell coordinate per step.
module gls_walk (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gls_pkg::walk_ctl_t   ctl,
    input  gls_pkg::walk_load_t  load_data,
    output gls_pkg::walk_stat_t  stat
);

    typedef enum logic [5:0] {
        PH_FROM   = 6'b000001,
        PH_TARGET = 6'b000010,
        PH_STEP   = 6'b000100,
        PH_SIDE2  = 6'b001000,
        PH_DIAG   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    localparam int CW = gls_pkg::COORD_W;
    localparam int OW = gls_pkg::ORDER_W;

    phase_t ph_reg, ph_next;

    logic [CW-1:0] px_reg, px_next;
    logic [CW-1:0] py_reg, py_next;
    logic [CW-1:0] tx_reg, tx_next;
    logic [CW-1:0] ty_reg, ty_next;
    logic [CW-1:0] cx_reg, cx_next;
    logic [CW-1:0] cy_reg, cy_next;
    logic [CW-1:0] cols_reg, cols_next;
    logic [CW-1:0] rows_reg, rows_next;
    logic          sxn_reg, sxn_next;
    logic          syn_reg, syn_next;
    logic signed [OW-1:0] order_reg, order_next;

    logic [CW-1:0] nx, ny;
    logic          more;
    logic signed [OW-1:0] two_rows, two_cols;
    logic [CW-1:0] ld_cols, ld_rows;

    // Neighbor coordinates and remaining-step test
    assign nx       = sxn_reg ? (px_reg - CW'(1)) : (px_reg + CW'(1));
    assign ny       = syn_reg ? (py_reg - CW'(1)) : (py_reg + CW'(1));
    assign more     = (cx_reg != cols_reg) || (cy_reg != rows_reg);
    assign two_rows = $signed({{(OW-CW-1){1'b0}}, rows_reg, 1'b0});
    assign two_cols = $signed({{(OW-CW-1){1'b0}}, cols_reg, 1'b0});

    // Span of a new query
    assign ld_cols = (load_data.to_x > load_data.from_x) ?
                     (load_data.to_x - load_data.from_x) : (load_data.from_x - load_data.to_x);
    assign ld_rows = (load_data.to_y > load_data.from_y) ?
                     (load_data.to_y - load_data.from_y) : (load_data.from_y - load_data.to_y);

    // Step logic
    always_comb
    begin
        ph_next    = ph_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        sxn_next   = sxn_reg;
        syn_next   = syn_reg;
        order_next = order_reg;

        stat.emit_valid = 1'b0;
        stat.emit_x     = px_reg;
        stat.emit_y     = py_reg;
        stat.done       = (ph_reg == PH_DONE);

        if (ctl.load)
        begin
            ph_next    = PH_FROM;
            px_next    = load_data.from_x;
            py_next    = load_data.from_y;
            tx_next    = load_data.to_x;
            ty_next    = load_data.to_y;
            cx_next    = '0;
            cy_next    = '0;
            cols_next  = ld_cols;
            rows_next  = ld_rows;
            sxn_next   = !(load_data.to_x > load_data.from_x);
            syn_next   = !(load_data.to_y > load_data.from_y);
            order_next = $signed({{(OW-CW){1'b0}}, ld_rows})
                       - $signed({{(OW-CW){1'b0}}, ld_cols});
        end
        else if (ctl.step)
        begin
            case (ph_reg)
                PH_FROM:
                begin
                    stat.emit_valid = 1'b1;
                    ph_next         = PH_TARGET;
                end
                PH_TARGET:
                begin
                    stat.emit_valid = 1'b1;
                    stat.emit_x     = tx_reg;
                    stat.emit_y     = ty_reg;
                    ph_next         = PH_STEP;
                end
                PH_STEP:
                begin
                    if (!more)
                    begin
                        ph_next = PH_DONE;
                    end
                    else if (order_reg == '0)
                    begin
                        // exact corner: first side cell
                        stat.emit_valid = 1'b1;
                        stat.emit_x     = nx;
                        ph_next         = PH_SIDE2;
                    end
                    else if (order_reg[OW-1])
                    begin
                        stat.emit_valid = 1'b1;
                        stat.emit_x     = nx;
                        px_next         = nx;
                        cx_next         = cx_reg + CW'(1);
                        order_next      = order_reg + two_rows;
                    end
                    else
                    begin
                        stat.emit_valid = 1'b1;
                        stat.emit_y     = ny;
                        py_next         = ny;
                        cy_next         = cy_reg + CW'(1);
                        order_next      = order_reg - two_cols;
                    end
                end
                PH_SIDE2:
                begin
                    stat.emit_valid = 1'b1;
                    stat.emit_y     = ny;
                    ph_next         = PH_DIAG;
                end
                PH_DIAG:
                begin
                    stat.emit_valid = 1'b1;
                    stat.emit_x     = nx;
                    stat.emit_y     = ny;
                    px_next         = nx;
                    py_next         = ny;
                    cx_next         = cx_reg + CW'(1);
                    cy_next         = cy_reg + CW'(1);
                    order_next      = order_reg + two_rows - two_cols;
                    ph_next         = PH_STEP;
                end
                PH_DONE:
                begin
                    ph_next = PH_DONE;
                end
                default:
                begin
                    ph_next = PH_DONE;
                end
            endcase
        end
    end

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_DONE;
        end
        else
        begin
            ph_reg <= ph_next;
        end
    end

    // Walk datapath
    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cols_reg  <= cols_next;
        rows_reg  <= rows_next;
        sxn_reg   <= sxn_next;
        syn_reg   <= syn_next;
        order_reg <= order_next;
    end

endmodule

// ===== sv/grid_line_of_sight_top.sv =====
// Top level: handshakes, configuration, store clearing and query control.
//
// Input channel (in_valid/in_stall) takes one transaction per item: a
// terrain write (command 0) or a line-of-sight query (command 1). Writes
// give no result; queries give exactly one result transaction on the
// output channel (out_valid/out_stall) carrying visible and coord_error.
// A write passes through ST_WRITE and then back to ST_IDLE. A query whose
// coordinates leave the grid goes straight to ST_FINISH with coord_error
// set. A walking query issues one terrain read per cycle through the
// single store port; it stops early at the first wall. One item is in
// work at a time. After reset the store is cleared to open, one cell per
// cycle, through all 4096 cells; in_stall stays high until that pass
// ends. grid_width and grid_height reset to 64; the user must write them
// through cfg_write only while the block is idle, which the block itself
// does not enforce. The result sits in an output register: a stalled
// receiver holds it, while the next item is already accepted; a further
// result waits inside until the register frees.
module grid_line_of_sight_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic [gls_pkg::COORD_W-1:0]     cell_x,
    input  logic [gls_pkg::COORD_W-1:0]     cell_y,
    input  logic [gls_pkg::KIND_W-1:0]      terrain_kind,
    input  logic [gls_pkg::COORD_W-1:0]     target_x,
    input  logic [gls_pkg::COORD_W-1:0]     target_y,
    input  logic                            cfg_write,
    input  logic [gls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gls_pkg::SIDE_W-1:0]      cfg_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            visible,
    output logic                            coord_error
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_WRITE  = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    localparam int CW = gls_pkg::COORD_W;
    localparam int SW = gls_pkg::SIDE_W;
    localparam int AW = gls_pkg::ADDR_W;
    localparam int KW = gls_pkg::KIND_W;

    state_t state_reg, state_next;

    logic [SW-1:0] grid_width_reg, grid_width_next;
    logic [SW-1:0] grid_height_reg, grid_height_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          res_vis_reg, res_vis_next;
    logic          res_err_reg, res_err_next;
    logic          out_valid_reg, out_valid_next;
    logic          visible_reg, visible_next;
    logic          coord_error_reg, coord_error_next;
    logic [CW-1:0] wr_x_reg, wr_x_next;
    logic [CW-1:0] wr_y_reg, wr_y_next;
    logic [KW-1:0] wr_kind_reg, wr_kind_next;
    logic          wr_ok_reg, wr_ok_next;

    logic [SW-1:0] w_eff, h_eff;
    logic          in_accept;
    logic          origin_in, target_in;
    logic          wall_hit;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [KW-1:0] ram_wdata;
    logic [KW-1:0] ram_rdata;

    gls_pkg::walk_ctl_t  walk_ctl;
    gls_pkg::walk_load_t walk_load;
    gls_pkg::walk_stat_t walk_stat;

    // Grid in effect and handshake decode
    assign w_eff     = gls_pkg::clamp_side(grid_width_reg);
    assign h_eff     = gls_pkg::clamp_side(grid_height_reg);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign origin_in = ({1'b0, cell_x} < w_eff) && ({1'b0, cell_y} < h_eff);
    assign target_in = ({1'b0, target_x} < w_eff) && ({1'b0, target_y} < h_eff);
    assign wall_hit  = rd_pend_reg && (ram_rdata == gls_pkg::KIND_WALL);
    assign out_free  = !out_valid_reg || !out_stall;

    // Walker hookup
    assign walk_load.from_x = cell_x;
    assign walk_load.from_y = cell_y;
    assign walk_load.to_x   = target_x;
    assign walk_load.to_y   = target_y;
    assign walk_ctl.load    = in_accept && (command == gls_pkg::CMD_QUERY)
                              && origin_in && target_in;
    assign walk_ctl.step    = (state_reg == ST_WALK);

    gls_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (walk_ctl),
        .load_data (walk_load),
        .stat      (walk_stat)
    );

    // Store port select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = gls_pkg::KIND_OPEN;
        ram_addr  = gls_pkg::cell_index(walk_stat.emit_x, walk_stat.emit_y, w_eff);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_addr_reg;
            end
            ST_WRITE:
            begin
                ram_we    = wr_ok_reg;
                ram_wdata = wr_kind_reg;
                ram_addr  = gls_pkg::cell_index(wr_x_reg, wr_y_reg, w_eff);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    gls_terrain_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Configuration writes
    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                gls_pkg::CFG_GRID_WIDTH:  grid_width_next  = cfg_data;
                gls_pkg::CFG_GRID_HEIGHT: grid_height_next = cfg_data;
                default:                  grid_width_next  = grid_width_reg;
            endcase
        end
    end

    // Controller
    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        rd_pend_next     = 1'b0;
        res_vis_next     = res_vis_reg;
        res_err_next     = res_err_reg;
        wr_x_next        = wr_x_reg;
        wr_y_next        = wr_y_reg;
        wr_kind_next     = wr_kind_reg;
        wr_ok_next       = wr_ok_reg;
        out_valid_next   = out_valid_reg && out_stall;
        visible_next     = visible_reg;
        coord_error_next = coord_error_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == gls_pkg::CMD_WRITE)
                    begin
                        wr_x_next    = cell_x;
                        wr_y_next    = cell_y;
                        wr_kind_next = terrain_kind;
                        wr_ok_next   = origin_in;
                        state_next   = ST_WRITE;
                    end
                    else if (!(origin_in && target_in))
                    begin
                        res_vis_next = 1'b0;
                        res_err_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                // one read issued per cycle, checked the cycle after
                if (wall_hit)
                begin
                    res_vis_next = 1'b0;
                    res_err_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else if (walk_stat.done && !rd_pend_reg)
                begin
                    res_vis_next = 1'b1;
                    res_err_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    rd_pend_next = walk_stat.emit_valid;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    visible_next     = res_vis_reg;
                    coord_error_next = res_err_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            grid_width_reg  <= gls_pkg::SIDE_RESET;
            grid_height_reg <= gls_pkg::SIDE_RESET;
            clr_addr_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            clr_addr_reg    <= clr_addr_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_vis_reg     <= res_vis_next;
        res_err_reg     <= res_err_next;
        wr_x_reg        <= wr_x_next;
        wr_y_reg        <= wr_y_next;
        wr_kind_reg     <= wr_kind_next;
        wr_ok_reg       <= wr_ok_next;
        visible_reg     <= visible_next;
        coord_error_reg <= coord_error_next;
    end

    assign out_valid   = out_valid_reg;
    assign visible     = visible_reg;
    assign coord_error = coord_error_reg;

endmodule
